// ===== design/wse_pkg.sv =====
// Shared types and constants for the weighted spring error core.
package wse_pkg;

  localparam int ROOT_STEPS = 35;
  localparam int DIV_STEPS  = 64;
  localparam int CNT_W      = 7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO_W = 2'd1;
  localparam logic [1:0] ST_UNUSED = 2'd2;

  typedef enum logic [3:0] {
    MS_SQX_LO, MS_SQX_HI, MS_SQY_LO, MS_SQY_HI, MS_SQZ_LO, MS_SQZ_HI,
    MS_DSQ_LO, MS_DSQ_HI, MS_WT0, MS_WT1, MS_WT2
  } mstep_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_RINIT, S_ROOT, S_DSQ, S_TERM, S_WT, S_COMMIT,
    S_CHECK, S_DINIT, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic   load;
    logic   mul_en;
    logic   acc_clr;
    mstep_t mstep;
    logic   root_init;
    logic   root_step;
    logic   term_load;
    logic   commit;
    logic   div_init;
    logic   div_step;
    logic   out_load;
  } wse_cmd_t;

  typedef struct packed {
    logic keep_in;
    logic last;
    logic pused;
    logic wsum_zero;
    logic out_free;
  } wse_stat_t;

endpackage

// ===== design/weighted_spring_error_core.sv =====
// Top level of the weighted spring error core.
// Each input transaction is one spring of the current point. A kept spring (neighbor
// used, and stable unless skip-unstable mode is off) takes six multiply steps for the
// squared distance, a 35-step bit-serial square root, two multiply steps for the squared
// length error, three for the weighting, and a commit, on the shared 36x18 multiplier
// and the one-bit-per-cycle root unit. A skipped spring goes straight to the check
// for the end of the point. The last spring of a point adds a result: stored directly
// when the point is unused or the total weight is zero, else after the 64-step restoring
// divide of the error sum by the weight sum. The result sits in an output register, so
// the next spring is taken while it waits; a new result waits only if the previous one
// is still stalled. error_status is 0 for a valid mean, 1 for zero weight, 2 for an
// unused point; error_value saturates at 2^48-1. The skip mode register resets to 1.
module weighted_spring_error_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic [31:0] in_point_z,
  input  logic [31:0] in_neighbor_x,
  input  logic [31:0] in_neighbor_y,
  input  logic [31:0] in_neighbor_z,
  input  logic        in_neighbor_used,
  input  logic        in_spring_stable,
  input  logic [15:0] in_spring_weight,
  input  logic [31:0] in_rest_length,
  input  logic        in_point_used,
  input  logic        in_last_spring,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_error_value,
  output logic [1:0]  out_error_status
);
  import wse_pkg::*;

  wse_cmd_t  cmd;
  wse_stat_t stat;

  // Sequence the steps of each transaction.
  wse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold operands, sums and the result register.
  wse_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .in_neighbor_x    (in_neighbor_x),
    .in_neighbor_y    (in_neighbor_y),
    .in_neighbor_z    (in_neighbor_z),
    .in_neighbor_used (in_neighbor_used),
    .in_spring_stable (in_spring_stable),
    .in_spring_weight (in_spring_weight),
    .in_rest_length   (in_rest_length),
    .in_point_used    (in_point_used),
    .in_last_spring   (in_last_spring),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_error_value  (out_error_value),
    .out_error_status (out_error_status)
  );

endmodule

// ===== design/wse_dp.sv =====
// Datapath: operand registers, shared multiplier, root and divide units, sums.
module wse_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  wse_pkg::wse_cmd_t  cmd,
  output wse_pkg::wse_stat_t stat,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic [31:0]        in_point_x,
  input  logic [31:0]        in_point_y,
  input  logic [31:0]        in_point_z,
  input  logic [31:0]        in_neighbor_x,
  input  logic [31:0]        in_neighbor_y,
  input  logic [31:0]        in_neighbor_z,
  input  logic               in_neighbor_used,
  input  logic               in_spring_stable,
  input  logic [15:0]        in_spring_weight,
  input  logic [31:0]        in_rest_length,
  input  logic               in_point_used,
  input  logic               in_last_spring,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [47:0]        out_error_value,
  output logic [1:0]         out_error_status
);
  import wse_pkg::*;

  function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  logic        skip_r;
  logic [32:0] ax_r, ay_r, az_r;
  logic [15:0] w_r;
  logic [31:0] len_r;
  logic        last_r, pused_r;
  logic [71:0] acc_r, acc_nxt;
  logic [69:0] rad_r;
  logic [36:0] rem_r;
  logic [34:0] root_r;
  logic [53:0] term_r;
  logic [63:0] esum_r;
  logic [31:0] wsum_r;
  logic [31:0] drem_r;
  logic [63:0] dq_r;
  logic        ovalid_r;
  logic [47:0] oval_r;
  logic [1:0]  ostat_r;

  logic [35:0] ma;
  logic [17:0] mb;
  logic [6:0]  msh;
  logic [53:0] prod;
  logic [34:0] diff;
  logic [34:0] len_ext;
  logic [38:0] r4, trial, rdiff;
  logic [32:0] dr, dsub;
  logic [63:0] term_w;
  logic [64:0] esum_add;
  logic [32:0] wsum_add;

  assign len_ext = {3'b0, len_r};
  assign diff    = (len_ext > root_r) ? len_ext - root_r : root_r - len_ext;

  always_comb begin
    ma  = 36'd0;
    mb  = 18'd0;
    msh = 7'd0;
    unique case (cmd.mstep)
      MS_SQX_LO: begin ma = {3'b0, ax_r}; mb = {1'b0, ax_r[16:0]}; end
      MS_SQX_HI: begin ma = {3'b0, ax_r}; mb = {2'b0, ax_r[32:17]}; msh = 7'd17; end
      MS_SQY_LO: begin ma = {3'b0, ay_r}; mb = {1'b0, ay_r[16:0]}; end
      MS_SQY_HI: begin ma = {3'b0, ay_r}; mb = {2'b0, ay_r[32:17]}; msh = 7'd17; end
      MS_SQZ_LO: begin ma = {3'b0, az_r}; mb = {1'b0, az_r[16:0]}; end
      MS_SQZ_HI: begin ma = {3'b0, az_r}; mb = {2'b0, az_r[32:17]}; msh = 7'd17; end
      MS_DSQ_LO: begin ma = {1'b0, diff}; mb = {1'b0, diff[16:0]}; end
      MS_DSQ_HI: begin ma = {1'b0, diff}; mb = diff[34:17]; msh = 7'd17; end
      MS_WT0:    begin ma = {20'b0, w_r}; mb = term_r[17:0]; end
      MS_WT1:    begin ma = {20'b0, w_r}; mb = term_r[35:18]; msh = 7'd18; end
      MS_WT2:    begin ma = {20'b0, w_r}; mb = term_r[53:36]; msh = 7'd36; end
      default:   begin ma = 36'd0; mb = 18'd0; end
    endcase
  end

  assign prod    = {18'b0, ma} * {36'b0, mb};
  assign acc_nxt = (cmd.acc_clr ? 72'd0 : acc_r) + ({18'b0, prod} << msh);

  assign r4    = {rem_r, rad_r[69:68]};
  assign trial = {2'b0, root_r, 2'b01};
  assign rdiff = r4 - trial;

  assign dr   = {drem_r, dq_r[63]};
  assign dsub = dr - {1'b0, wsum_r};

  assign term_w   = (acc_r[71:64] != 8'd0) ? {64{1'b1}} : acc_r[63:0];
  assign esum_add = {1'b0, esum_r} + {1'b0, term_w};
  assign wsum_add = {1'b0, wsum_r} + {17'b0, w_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r   <= 1'b1;
      ovalid_r <= 1'b0;
      esum_r   <= 64'd0;
      wsum_r   <= 32'd0;
    end else begin
      if (cfg_we) begin
        skip_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        esum_r <= esum_add[64] ? {64{1'b1}} : esum_add[63:0];
        wsum_r <= wsum_add[32] ? {32{1'b1}} : wsum_add[31:0];
      end
      if (cmd.out_load) begin
        ovalid_r <= 1'b1;
        esum_r   <= 64'd0;
        wsum_r   <= 32'd0;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r    <= absd(in_point_x, in_neighbor_x);
      ay_r    <= absd(in_point_y, in_neighbor_y);
      az_r    <= absd(in_point_z, in_neighbor_z);
      w_r     <= in_spring_weight;
      len_r   <= in_rest_length;
      last_r  <= in_last_spring;
      pused_r <= in_point_used;
    end
    if (cmd.mul_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.root_init) begin
      rad_r  <= {4'b0, acc_r[65:0]};
      rem_r  <= 37'd0;
      root_r <= 35'd0;
    end else if (cmd.root_step) begin
      rad_r <= {rad_r[67:0], 2'b00};
      if (!rdiff[38]) begin
        rem_r  <= rdiff[36:0];
        root_r <= {root_r[33:0], 1'b1};
      end else begin
        rem_r  <= r4[36:0];
        root_r <= {root_r[33:0], 1'b0};
      end
    end
    if (cmd.term_load) begin
      term_r <= acc_r[69:16];
    end
    if (cmd.div_init) begin
      drem_r <= 32'd0;
      dq_r   <= esum_r;
    end else if (cmd.div_step) begin
      if (!dsub[32]) begin
        drem_r <= dsub[31:0];
        dq_r   <= {dq_r[62:0], 1'b1};
      end else begin
        drem_r <= dr[31:0];
        dq_r   <= {dq_r[62:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      priority if (!pused_r) begin
        oval_r  <= 48'd0;
        ostat_r <= ST_UNUSED;
      end else if (wsum_r == 32'd0) begin
        oval_r  <= 48'd0;
        ostat_r <= ST_ZERO_W;
      end else begin
        oval_r  <= (dq_r[63:48] != 16'd0) ? {48{1'b1}} : dq_r[47:0];
        ostat_r <= ST_OK;
      end
    end
  end

  assign stat.keep_in   = in_neighbor_used & ~(skip_r & ~in_spring_stable);
  assign stat.last      = last_r;
  assign stat.pused     = pused_r;
  assign stat.wsum_zero = (wsum_r == 32'd0);
  assign stat.out_free  = ~ovalid_r | ~out_stall;

  assign out_valid        = ovalid_r;
  assign out_error_value  = oval_r;
  assign out_error_status = ostat_r;

`ifndef SYNTH
  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (esum_r == 64'd0) && (wsum_r == 32'd0))
    else $error("sums not cleared after result");
  a_out_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (ostat_r == ST_OK) || (ostat_r == ST_ZERO_W) || (ostat_r == ST_UNUSED))
    else $error("bad result status");
  a_ok_nonzero_w: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> (wsum_r != 32'd0) && pused_r)
    else $error("divide started with zero weight or unused point");
`endif

endmodule

// ===== design/wse_ctrl.sv =====
// Controller: sequences multiply, root, commit and divide steps per transaction.
module wse_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wse_pkg::wse_stat_t stat,
  output wse_pkg::wse_cmd_t  cmd
);
  import wse_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mstep = MS_SQX_LO;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = stat.keep_in ? S_SQ : S_CHECK;
        end
      end
      S_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = (cnt_r == '0);
        unique case (cnt_r[2:0])
          3'd0:    cmd.mstep = MS_SQX_LO;
          3'd1:    cmd.mstep = MS_SQX_HI;
          3'd2:    cmd.mstep = MS_SQY_LO;
          3'd3:    cmd.mstep = MS_SQY_HI;
          3'd4:    cmd.mstep = MS_SQZ_LO;
          default: cmd.mstep = MS_SQZ_HI;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(5)) begin
          cnt_nxt   = '0;
          state_nxt = S_RINIT;
        end
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DSQ;
        end
      end
      S_DSQ: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = (cnt_r == '0);
        cmd.mstep   = (cnt_r == '0) ? MS_DSQ_LO : MS_DSQ_HI;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt   = '0;
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        cmd.term_load = 1'b1;
        state_nxt     = S_WT;
      end
      S_WT: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = (cnt_r == '0);
        unique case (cnt_r[1:0])
          2'd0:    cmd.mstep = MS_WT0;
          2'd1:    cmd.mstep = MS_WT1;
          default: cmd.mstep = MS_WT2;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(2)) begin
          cnt_nxt   = '0;
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        priority if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (!stat.pused || stat.wsum_zero) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start");
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result overwrote pending output");
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> (cnt_r < CNT_W'(ROOT_STEPS)))
    else $error("root iteration count out of range");
`endif

endmodule

// ===== verif/tb_weighted_spring_error_core.sv =====
// Testbench for weighted_spring_error_core: random springs checked against a predictor.
module tb_weighted_spring_error_core;
  timeunit 1ns;
  timeprecision 1ps;
  import wse_pkg::*;

  typedef struct {
    logic [31:0] px, py, pz, nx, ny, nz;
    logic        nused, stable;
    logic [15:0] wt;
    logic [31:0] rest;
    logic        pused, last;
  } spring_t;

  typedef struct {
    logic [47:0] value;
    logic [1:0]  status;
  } point_err_t;

  // Scoreboard: predicts the per-point mean error and checks results in order.
  class spring_error_board;
    bit          skip_mode;
    logic [63:0] err_acc;
    logic [31:0] wt_acc;
    point_err_t  pending[$];
    int          fails;
    int          points;

    function void clear();
      skip_mode = 1;
      err_acc = '0;
      wt_acc = '0;
      pending.delete();
      fails = 0;
      points = 0;
    endfunction

    function logic [33:0] root_floor(logic [67:0] v);
      logic [34:0]  r;
      logic [34:0]  c;
      logic [69:0]  sq;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
        c = r | (35'd1 << b);
        sq = c * c;
        if (sq <= {2'b00, v}) r = c;
      end
      return r[33:0];
    endfunction

    function void note_spring(spring_t s);
      logic signed [32:0] d;
      logic [32:0]        a;
      logic [67:0]        dsq;
      logic [33:0]        root_d;
      logic [33:0]        diff;
      logic [67:0]        dd;
      logic [63:0]        term;
      logic [79:0]        prod;
      logic [63:0]        lo;
      logic [64:0]        esum;
      logic [32:0]        wsum;
      point_err_t         r;
      logic [63:0]        q;
      if (s.nused && !(skip_mode && !s.stable)) begin
        dsq = '0;
        d = $signed(s.px) - $signed(s.nx);
        a = (d < 0) ? -d : d;
        dsq += a * a;
        d = $signed(s.py) - $signed(s.ny);
        a = (d < 0) ? -d : d;
        dsq += a * a;
        d = $signed(s.pz) - $signed(s.nz);
        a = (d < 0) ? -d : d;
        dsq += a * a;
        root_d = root_floor(dsq);
        diff = ({2'b00, s.rest} > root_d) ? {2'b00, s.rest} - root_d
                                          : root_d - {2'b00, s.rest};
        dd = diff * diff;
        term = {12'b0, dd[67:16]}; // fits: high bits above 64 are zero after shift
        prod = term * s.wt;
        lo = (prod[79:64] != 0) ? '1 : prod[63:0];
        esum = err_acc + lo;
        err_acc = esum[64] ? '1 : esum[63:0];
        wsum = wt_acc + s.wt;
        wt_acc = wsum[32] ? '1 : wsum[31:0];
      end
      if (!s.last) return;
      if (!s.pused) begin
        r.value = '0; r.status = ST_UNUSED;
      end else if (wt_acc == 0) begin
        r.value = '0; r.status = ST_ZERO_W;
      end else begin
        q = err_acc / wt_acc;
        r.value = (q > 64'hFFFF_FFFF_FFFF) ? '1 : q[47:0];
        r.status = ST_OK;
      end
      pending.push_back(r);
      err_acc = '0;
      wt_acc = '0;
    endfunction

    function void check_result(logic [47:0] v, logic [1:0] st);
      point_err_t e;
      points++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time, v, st);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (v !== e.value || st !== e.status) begin
        $display("%0t: expected value=%h status=%0d, actual value=%h status=%0d",
                 $time, e.value, e.status, v, st);
        fails++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_we, cfg_wdata;
  logic        in_valid, in_stall;
  logic [31:0] in_point_x, in_point_y, in_point_z;
  logic [31:0] in_neighbor_x, in_neighbor_y, in_neighbor_z;
  logic        in_neighbor_used, in_spring_stable;
  logic [15:0] in_spring_weight;
  logic [31:0] in_rest_length;
  logic        in_point_used, in_last_spring;
  logic        out_valid, out_stall;
  logic [47:0] out_error_value;
  logic [1:0]  out_error_status;

  spring_error_board board;
  bit  stim_done;
  int  springs_sent;

  weighted_spring_error_core DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Pick a gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Random 32-bit coordinate: full range, small, or near extremes.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return 32'h7FFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  function automatic spring_t rand_spring(bit last);
    spring_t s;
    s.px = rand_coord(); s.py = rand_coord(); s.pz = rand_coord();
    if ($urandom_range(0, 1)) begin
      // Neighbor close to the point, so distances are near a realistic rest length.
      s.nx = s.px + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      s.ny = s.py + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      s.nz = s.pz + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      s.rest = $urandom_range(0, 32'h0003_0000);
    end else begin
      s.nx = rand_coord(); s.ny = rand_coord(); s.nz = rand_coord();
      s.rest = $urandom;
    end
    s.nused  = ($urandom_range(0, 9) != 0);
    s.stable = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 5))
      0: s.wt = 16'h0000;
      1: s.wt = 16'hFFFF;
      default: s.wt = $urandom;
    endcase
    s.pused = ($urandom_range(0, 7) != 0);
    s.last = last;
    return s;
  endfunction

  // Drive one spring and hold it until accepted; valid stays up after acceptance.
  task automatic send_spring(spring_t s);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= s.px; in_point_y <= s.py; in_point_z <= s.pz;
    in_neighbor_x <= s.nx; in_neighbor_y <= s.ny; in_neighbor_z <= s.nz;
    in_neighbor_used <= s.nused; in_spring_stable <= s.stable;
    in_spring_weight <= s.wt; in_rest_length <= s.rest;
    in_point_used <= s.pused; in_last_spring <= s.last;
    do @(posedge clk); while (in_stall);
    board.note_spring(s);
    springs_sent++;
  endtask

  // Drop valid once the last transaction has been taken.
  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every result has arrived and the core has drained.
  task automatic drain();
    stop_input();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_mode(bit m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.skip_mode = m;
  endtask

  // Send one point of n random springs.
  task automatic send_point(int n);
    for (int i = 0; i < n; i++) send_spring(rand_spring(i == n - 1));
  endtask

  // Result side: random stalls, sample at the rising edge.
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 9) < 3) begin
        g = gap_len();
        if (g != 0) begin
          out_stall <= 1'b1;
          repeat (g) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_error_value, out_error_status);
  end

  // Stimulus
  initial begin
    spring_t s;
    board = new();
    board.clear();
    stim_done = 0;
    springs_sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0;
    in_neighbor_x = '0; in_neighbor_y = '0; in_neighbor_z = '0;
    in_neighbor_used = 1'b0; in_spring_stable = 1'b0;
    in_spring_weight = '0; in_rest_length = '0;
    in_point_used = 1'b0; in_last_spring = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme coordinates with max rest length and weight, to saturate.
    s = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1, 1, 16'hFFFF, 32'h0, 1, 0};
    repeat (3) send_spring(s);
    s.rest = 32'hFFFF_FFFF; s.last = 1;
    send_spring(s);
    // Zero weight on every spring.
    s = '{32'h0001_0000, 0, 0, 0, 0, 0, 1, 1, 16'h0, 32'h0001_0000, 1, 1};
    send_spring(s);
    // Unused point.
    s.wt = 16'h0100; s.pused = 0;
    send_spring(s);
    // Unused neighbor only: zero weight result.
    s.nused = 0; s.pused = 1;
    send_spring(s);
    // Unstable spring while skipping, then a normal spring closing the point.
    s = '{32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 1, 0, 16'h0100, 32'h0004_0000, 1, 0};
    send_spring(s);
    s.stable = 1; s.last = 1;
    send_spring(s);
    // Identical points: zero distance, all fields ones elsewhere.
    s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 1, 1, 16'hFFFF, 32'hFFFF_FFFF, 1, 1};
    send_spring(s);
    // Pause until everything has come back.
    drain();

    // Unstable springs counted once skipping is off.
    write_mode(1'b0);
    s = '{32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 1, 0, 16'h0080, 32'h0002_0000, 1, 1};
    send_spring(s);
    s.nused = 0;
    send_spring(s);
    drain();

    // Random phases over both mode settings.
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      while (springs_sent < 20 + (ph + 1) * 470) begin
        if ($urandom_range(0, 19) == 0) send_point($urandom_range(20, 60));
        else send_point($urandom_range(1, 6));
      end
      drain();
    end
    stim_done = 1;
  end

  // Finish once the stimulus has drained.
  initial begin
    wait (stim_done);
    $display("Sent %0d springs, checked %0d point results in both skip modes.",
             springs_sent, board.points);
    if (board.fails == 0 && board.pending.size() == 0)
      $display("weighted_spring_error_core: match");
    else
      $display("weighted_spring_error_core: mismatch");
    $finish;
  end

  // Timeout guard.
  initial begin
    #20ms;
    $display("weighted_spring_error_core: mismatch");
    $finish;
  end
endmodule
